// File: rtl/core/mer_pkg.sv
package mer_pkg;

    localparam int OUT_W       = 12;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_AB,
        ST_INIT,
        ST_EMIT,
        ST_SW_SQX,
        ST_SW_BX,
        ST_SW_SQY,
        ST_SW_AY,
        ST_SW_AB,
        ST_SW_FIN,
        ST_R2
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_A,
        OP_SQ_B,
        OP_AB,
        OP_INIT,
        OP_EMIT,
        OP_SW_SQX,
        OP_SW_BX,
        OP_SW_SQY,
        OP_SW_AY,
        OP_SW_AB,
        OP_SW_FIN,
        OP_R2
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic region_two;
        logic stay_r1;
    } status_t;

endpackage

// File: rtl/core/mer_ctrl.sv
module mer_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              m_tready,
    output logic              m_tvalid,
    input  mer_pkg::status_t  status,
    output mer_pkg::cmd_t     cmd,
    output mer_pkg::state_t   state
);

    mer_pkg::state_t state_reg;
    mer_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign state    = state_reg;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mer_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = mer_pkg::ST_SQ_A;
                end
            end
            mer_pkg::ST_SQ_A:   state_next = mer_pkg::ST_SQ_B;
            mer_pkg::ST_SQ_B:   state_next = mer_pkg::ST_AB;
            mer_pkg::ST_AB:     state_next = mer_pkg::ST_INIT;
            mer_pkg::ST_INIT:   state_next = mer_pkg::ST_EMIT;
            mer_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    priority if (status.last)
                    begin
                        state_next = mer_pkg::ST_IDLE;
                    end
                    else if (!status.region_two && !status.stay_r1)
                    begin
                        state_next = mer_pkg::ST_SW_SQX;
                    end
                    else
                    begin
                        state_next = mer_pkg::ST_EMIT;
                    end
                end
            end
            mer_pkg::ST_SW_SQX: state_next = mer_pkg::ST_SW_BX;
            mer_pkg::ST_SW_BX:  state_next = mer_pkg::ST_SW_SQY;
            mer_pkg::ST_SW_SQY: state_next = mer_pkg::ST_SW_AY;
            mer_pkg::ST_SW_AY:  state_next = mer_pkg::ST_SW_AB;
            mer_pkg::ST_SW_AB:  state_next = mer_pkg::ST_SW_FIN;
            mer_pkg::ST_SW_FIN: state_next = mer_pkg::ST_R2;
            mer_pkg::ST_R2:     state_next = mer_pkg::ST_EMIT;
            default:            state_next = mer_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = mer_pkg::OP_NONE;
        s_tready = 1'b0;
        unique case (state_reg)
            mer_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op = mer_pkg::OP_LOAD;
                end
            end
            mer_pkg::ST_SQ_A:   cmd.op = mer_pkg::OP_SQ_A;
            mer_pkg::ST_SQ_B:   cmd.op = mer_pkg::OP_SQ_B;
            mer_pkg::ST_AB:     cmd.op = mer_pkg::OP_AB;
            mer_pkg::ST_INIT:   cmd.op = mer_pkg::OP_INIT;
            mer_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.op = mer_pkg::OP_EMIT;
                end
            end
            mer_pkg::ST_SW_SQX: cmd.op = mer_pkg::OP_SW_SQX;
            mer_pkg::ST_SW_BX:  cmd.op = mer_pkg::OP_SW_BX;
            mer_pkg::ST_SW_SQY: cmd.op = mer_pkg::OP_SW_SQY;
            mer_pkg::ST_SW_AY:  cmd.op = mer_pkg::OP_SW_AY;
            mer_pkg::ST_SW_AB:  cmd.op = mer_pkg::OP_SW_AB;
            mer_pkg::ST_SW_FIN: cmd.op = mer_pkg::OP_SW_FIN;
            mer_pkg::ST_R2:     cmd.op = mer_pkg::OP_R2;
            default:            cmd.op = mer_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.op == mer_pkg::OP_EMIT)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mer_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/mer_dp.sv
module mer_dp #(
    parameter int RADIUS_BITS = 5,
    parameter int COORD_BITS  = 10
) (
    input  logic                          clk,
    input  mer_pkg::cmd_t                 cmd,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic [RADIUS_BITS-1:0]        semi_axis_x,
    input  logic [RADIUS_BITS-1:0]        semi_axis_y,
    output mer_pkg::status_t              status,
    output logic signed [mer_pkg::OUT_W-1:0] x_right,
    output logic signed [mer_pkg::OUT_W-1:0] x_left,
    output logic signed [mer_pkg::OUT_W-1:0] y_top,
    output logic signed [mer_pkg::OUT_W-1:0] y_bottom,
    output logic                          last_point
);

    localparam int R  = RADIUS_BITS;
    localparam int OW = 2 * R + 2;
    localparam int PW = 2 * OW;
    localparam int DW = 4 * R + 6;
    localparam int SQ = 2 * R;
    localparam int WW = COORD_BITS + RADIUS_BITS + mer_pkg::OUT_W;

    logic [COORD_BITS-1:0]     cx_reg, cx_next;
    logic [COORD_BITS-1:0]     cy_reg, cy_next;
    logic [R-1:0]              b_reg, b_next;
    logic [R-1:0]              a_reg, a_next;
    logic [R-1:0]              x_reg, x_next;
    logic [R-1:0]              y_reg, y_next;
    logic [SQ-1:0]             a2_reg, a2_next;
    logic [SQ-1:0]             b2_reg, b2_next;
    logic [PW-1:0]             prod_reg, prod_next;
    logic signed [DW-1:0]      d_reg, d_next;
    logic signed [DW-1:0]      t1_reg, t1_next;
    logic signed [DW-1:0]      t2_reg, t2_next;
    logic signed [DW-1:0]      incx_reg, incx_next;
    logic signed [DW-1:0]      incy_reg, incy_next;
    logic                      r2_reg, r2_next;
    logic [mer_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [mer_pkg::OUT_W-1:0] xr_reg, xr_next;
    logic signed [mer_pkg::OUT_W-1:0] xl_reg, xl_next;
    logic signed [mer_pkg::OUT_W-1:0] yt_reg, yt_next;
    logic signed [mer_pkg::OUT_W-1:0] yb_reg, yb_next;
    logic                             lp_reg, lp_next;

    logic [OW-1:0]        mul_a;
    logic [OW-1:0]        mul_b;
    logic [PW-1:0]        mul_p;
    logic signed [DW-1:0] a2_s;
    logic signed [DW-1:0] b2_s;
    logic signed [DW-1:0] prod_s;
    logic                 d_le;
    logic                 stay_r1;
    logic                 last;
    logic [WW-1:0]        cx_w;
    logic [WW-1:0]        cy_w;
    logic [WW-1:0]        x_w;
    logic [WW-1:0]        y_w;
    logic [WW-1:0]        sum_xr;
    logic [WW-1:0]        sum_xl;
    logic [WW-1:0]        sum_yt;
    logic [WW-1:0]        sum_yb;

    assign a2_s    = signed'(DW'(a2_reg));
    assign b2_s    = signed'(DW'(b2_reg));
    assign prod_s  = signed'(DW'(prod_reg));
    assign d_le    = (d_reg <= 0);
    assign stay_r1 = (t1_reg < t2_reg);
    assign last    = (cnt_reg == mer_pkg::CNT_W'(mer_pkg::MAX_RESULTS - 1)) || (y_reg == '0);

    assign status.last       = last;
    assign status.region_two = r2_reg;
    assign status.stay_r1    = stay_r1;

    assign cx_w   = WW'(cx_reg);
    assign cy_w   = WW'(cy_reg);
    assign x_w    = WW'(x_reg);
    assign y_w    = WW'(y_reg);
    assign sum_xr = cx_w + x_w;
    assign sum_xl = cx_w - x_w;
    assign sum_yt = cy_w + y_w;
    assign sum_yb = cy_w - y_w;

    // one shared multiplier, operands picked per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            mer_pkg::OP_SQ_A:
            begin
                mul_a = OW'(a_reg);
                mul_b = OW'(a_reg);
            end
            mer_pkg::OP_SQ_B:
            begin
                mul_a = OW'(b_reg);
                mul_b = OW'(b_reg);
            end
            mer_pkg::OP_AB:
            begin
                mul_a = OW'(a2_reg);
                mul_b = OW'(b_reg);
            end
            mer_pkg::OP_SW_SQX:
            begin
                mul_a = OW'({x_reg, 1'b1});
                mul_b = OW'({x_reg, 1'b1});
            end
            mer_pkg::OP_SW_BX:
            begin
                mul_a = OW'(b2_reg);
                mul_b = prod_reg[OW-1:0];
            end
            mer_pkg::OP_SW_SQY:
            begin
                mul_a = OW'(R'(y_reg - 1'b1));
                mul_b = OW'(R'(y_reg - 1'b1));
            end
            mer_pkg::OP_SW_AY:
            begin
                mul_a = OW'(a2_reg);
                mul_b = prod_reg[OW-1:0];
            end
            mer_pkg::OP_SW_AB:
            begin
                mul_a = OW'(a2_reg);
                mul_b = OW'(b2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        a2_next   = a2_reg;
        b2_next   = b2_reg;
        prod_next = prod_reg;
        d_next    = d_reg;
        t1_next   = t1_reg;
        t2_next   = t2_reg;
        incx_next = incx_reg;
        incy_next = incy_reg;
        r2_next   = r2_reg;
        cnt_next  = cnt_reg;
        xr_next   = xr_reg;
        xl_next   = xl_reg;
        yt_next   = yt_reg;
        yb_next   = yb_reg;
        lp_next   = lp_reg;
        unique case (cmd.op)
            mer_pkg::OP_NONE:
            begin
                cnt_next = cnt_reg;
            end
            mer_pkg::OP_LOAD:
            begin
                cx_next  = center_x;
                cy_next  = center_y;
                a_next   = semi_axis_x;
                b_next   = semi_axis_y;
                x_next   = '0;
                y_next   = semi_axis_y;
                r2_next  = 1'b0;
                cnt_next = '0;
            end
            mer_pkg::OP_SQ_A:
            begin
                prod_next = mul_p;
            end
            mer_pkg::OP_SQ_B:
            begin
                a2_next   = prod_reg[SQ-1:0];
                prod_next = mul_p;
            end
            mer_pkg::OP_AB:
            begin
                b2_next   = prod_reg[SQ-1:0];
                prod_next = mul_p;
            end
            mer_pkg::OP_INIT:
            begin
                // prod holds a^2 * b here
                d_next    = (b2_s <<< 2) - (prod_s <<< 2) + a2_s;
                t1_next   = b2_s <<< 1;
                t2_next   = (prod_s <<< 1) - a2_s;
                incx_next = (b2_s <<< 3) + (b2_s <<< 2);
                incy_next = (a2_s <<< 3) - (prod_s <<< 3);
            end
            mer_pkg::OP_EMIT:
            begin
                xr_next  = sum_xr[mer_pkg::OUT_W-1:0];
                xl_next  = sum_xl[mer_pkg::OUT_W-1:0];
                yt_next  = sum_yt[mer_pkg::OUT_W-1:0];
                yb_next  = sum_yb[mer_pkg::OUT_W-1:0];
                lp_next  = last;
                cnt_next = cnt_reg + 1'b1;
                if (!last)
                begin
                    priority if (r2_reg)
                    begin
                        if (d_le)
                        begin
                            d_next    = d_reg + incx_reg + incy_reg;
                            x_next    = x_reg + 1'b1;
                            incx_next = incx_reg + (b2_s <<< 3);
                        end
                        else
                        begin
                            d_next = d_reg + incy_reg;
                        end
                        y_next    = y_reg - 1'b1;
                        incy_next = incy_reg + (a2_s <<< 3);
                    end
                    else if (stay_r1)
                    begin
                        if (d_le)
                        begin
                            d_next = d_reg + incx_reg;
                        end
                        else
                        begin
                            d_next    = d_reg + incx_reg + incy_reg;
                            y_next    = y_reg - 1'b1;
                            incy_next = incy_reg + (a2_s <<< 3);
                            t2_next   = t2_reg - (a2_s <<< 1);
                        end
                        x_next    = x_reg + 1'b1;
                        incx_next = incx_reg + (b2_s <<< 3);
                        t1_next   = t1_reg + (b2_s <<< 1);
                    end
                    else
                    begin
                        // region one done, switch sequence follows
                        r2_next = r2_reg;
                    end
                end
            end
            mer_pkg::OP_SW_SQX:
            begin
                prod_next = mul_p;
            end
            mer_pkg::OP_SW_BX:
            begin
                prod_next = mul_p;
            end
            mer_pkg::OP_SW_SQY:
            begin
                d_next    = prod_s;
                prod_next = mul_p;
            end
            mer_pkg::OP_SW_AY:
            begin
                prod_next = mul_p;
            end
            mer_pkg::OP_SW_AB:
            begin
                d_next    = d_reg + (prod_s <<< 2);
                prod_next = mul_p;
            end
            mer_pkg::OP_SW_FIN:
            begin
                d_next    = d_reg - (prod_s <<< 2);
                incx_next = t1_reg <<< 2;
                incy_next = (a2_s <<< 3) - (t2_reg <<< 2);
                r2_next   = 1'b1;
            end
            mer_pkg::OP_R2:
            begin
                // first region two step, y is above zero here
                if (d_le)
                begin
                    d_next    = d_reg + incx_reg + incy_reg;
                    x_next    = x_reg + 1'b1;
                    incx_next = incx_reg + (b2_s <<< 3);
                end
                else
                begin
                    d_next = d_reg + incy_reg;
                end
                y_next    = y_reg - 1'b1;
                incy_next = incy_reg + (a2_s <<< 3);
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        a2_reg   <= a2_next;
        b2_reg   <= b2_next;
        prod_reg <= prod_next;
        d_reg    <= d_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        incx_reg <= incx_next;
        incy_reg <= incy_next;
        r2_reg   <= r2_next;
        cnt_reg  <= cnt_next;
        xr_reg   <= xr_next;
        xl_reg   <= xl_next;
        yt_reg   <= yt_next;
        yb_reg   <= yb_next;
        lp_reg   <= lp_next;
    end

    assign x_right    = xr_reg;
    assign x_left     = xl_reg;
    assign y_top      = yt_reg;
    assign y_bottom   = yb_reg;
    assign last_point = lp_reg;

endmodule

// File: rtl/core/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer. Each input word is one ellipse: a center and
// the two semi-axes. The block walks the first quadrant with the two-region
// midpoint algorithm and sends one output word per plotted point, carrying
// the four mirrored coordinates; tlast marks the final point of the ellipse
// (at most 64 points). After an ellipse is accepted, the block runs the setup
// states SQ_A, SQ_B, AB and INIT, then emits one point per cycle while the
// output does not stall, and at the switch from region one to region two it
// runs the states SW_SQX to SW_FIN and R2; after the last point it returns to
// idle, where the next ellipse is taken. The setup and switch sequences use
// the one shared multiplier. A new ellipse is taken only after the last point
// of the previous one has been loaded into the output register; that word may
// still wait on the output side while the next ellipse is accepted.
module midpoint_ellipse_rasterizer #(
    parameter int RADIUS_BITS = 5,
    parameter int COORD_BITS  = 10
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // center_x, center_y, semi_axis_x, semi_axis_y
    input  logic [((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // x_right, x_left, y_top, y_bottom
    output logic [4 * mer_pkg::OUT_W - 1:0] m_tdata,
    output logic m_tlast
);

    localparam int C = COORD_BITS;
    localparam int R = RADIUS_BITS;

    mer_pkg::cmd_t    cmd;
    mer_pkg::status_t status;
    mer_pkg::state_t  state;

    logic signed [mer_pkg::OUT_W-1:0] x_right;
    logic signed [mer_pkg::OUT_W-1:0] x_left;
    logic signed [mer_pkg::OUT_W-1:0] y_top;
    logic signed [mer_pkg::OUT_W-1:0] y_bottom;

    mer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    mer_dp #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .center_x    (s_tdata[C-1:0]),
        .center_y    (s_tdata[2*C-1:C]),
        .semi_axis_x (s_tdata[2*C+R-1:2*C]),
        .semi_axis_y (s_tdata[2*C+2*R-1:2*C+R]),
        .status      (status),
        .x_right     (x_right),
        .x_left      (x_left),
        .y_top       (y_top),
        .y_bottom    (y_bottom),
        .last_point  (m_tlast)
    );

    assign m_tdata = {y_bottom, y_top, x_left, x_right};

    // an accepted ellipse always blocks the input in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken twice in a row");

    // the output register is loaded only when its word is gone or leaving
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == mer_pkg::OP_EMIT) |-> (!m_tvalid || m_tready))
    else $error("output word overwritten");

    // a word flagged last ends the walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == mer_pkg::OP_EMIT && status.last) |=> (state == mer_pkg::ST_IDLE))
    else $error("walk continued past last point");

    // the switch sequence only starts from region one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state == mer_pkg::ST_SW_SQX) |-> !status.region_two)
    else $error("region switch entered twice");

endmodule
